### sv/hpl_pkg.sv
// Package for the Hata path loss cell: constants, pipeline types and
// Q16 arithmetic and log2 helper functions. No dependencies.
`default_nettype none
package hpl_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FREQ    = 3'd0;
  localparam logic [2:0] REG_ANT     = 3'd1;
  localparam logic [2:0] REG_TXG     = 3'd2;
  localparam logic [2:0] REG_RADIUS  = 3'd3;
  localparam logic [2:0] REG_AREA    = 3'd4;
  localparam logic [2:0] REG_DEFG    = 3'd5;

  localparam logic [1:0] AREA_URBAN  = 2'd0;
  localparam logic [1:0] AREA_SUB    = 2'd1;
  localparam logic [1:0] AREA_OPEN   = 2'd2;

  localparam int CFG_W = 23;

  // Q16 coefficients
  localparam logic signed [31:0] C_LOG10_2  = 32'sd19728;
  localparam logic signed [31:0] C_LOG10_28 = 32'sd94841;
  localparam logic signed [31:0] C_69_55    = 32'sd4558029;
  localparam logic signed [31:0] C_26_16    = 32'sd1714422;
  localparam logic signed [31:0] C_13_82    = 32'sd905708;
  localparam logic signed [31:0] C_44_9     = 32'sd2942566;
  localparam logic signed [31:0] C_6_55     = 32'sd429261;
  localparam logic signed [31:0] C_1_1      = 32'sd72090;
  localparam logic signed [31:0] C_0_7      = 32'sd45875;
  localparam logic signed [31:0] C_RX_H     = 32'sd98304;
  localparam logic signed [31:0] C_1_56     = 32'sd102236;
  localparam logic signed [31:0] C_0_8      = 32'sd52429;
  localparam logic signed [31:0] C_4_78     = 32'sd313262;
  localparam logic signed [31:0] C_18_33    = 32'sd1201275;
  localparam logic signed [31:0] C_40_94    = 32'sd2683044;
  localparam logic signed [31:0] C_5_4      = 32'sd353894;
  localparam logic signed [31:0] LOG2_16    = 32'sd262144;
  localparam logic [47:0]        MIN_DSQ    = 48'd25600;

  // pipeline stage numbers
  localparam int ST_SQ    = 2;
  localparam int ST_DSQ   = 3;
  localparam int ST_SQRT0 = 4;
  localparam int SQRT_N   = 24;
  localparam int ST_NORM  = ST_SQRT0 + SQRT_N;
  localparam int ST_LOG0  = ST_NORM + 1;
  localparam int LOG_N    = 16;
  localparam int ST_P0    = ST_LOG0 + LOG_N;
  localparam int ST_L     = ST_P0 + 1;
  localparam int ST_M1    = ST_L + 1;
  localparam int ST_M2    = ST_M1 + 1;
  localparam int ST_M3    = ST_M2 + 1;
  localparam int ST_M4    = ST_M3 + 1;
  localparam int NST      = ST_M4 + 1;

  typedef struct packed {
    logic [30:0] m;
    logic [20:0] r;
  } lg_t;

  typedef struct packed {
    logic signed [18:0] h;
    logic signed [23:0] e;
    logic signed [23:0] n;
    logic [47:0]        esq;
    logic [47:0]        nsq;
    logic [23:0]        heff;
    logic               inval;
    logic [47:0]        v;
    logic [47:0]        r;
    lg_t                gf;
    lg_t                gh;
    lg_t                gd;
    logic signed [63:0] pf;
    logic signed [63:0] ph;
    logic signed [63:0] pd;
    logic signed [31:0] lf;
    logic signed [31:0] lh;
    logic signed [31:0] ld;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] p5;
    logic signed [63:0] p6;
    logic signed [63:0] p7;
    logic signed [63:0] p8;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] t4;
    logic signed [31:0] t7;
    logic signed [31:0] t8;
    logic signed [63:0] q1;
    logic signed [63:0] q2;
    logic signed [63:0] q3;
    logic signed [31:0] ahr;
    logic signed [31:0] base;
    logic signed [31:0] u2;
    logic signed [31:0] u3;
    logic signed [31:0] loss;
    logic [23:0]        po;
  } hpl_pl_t;

  function automatic logic signed [63:0] mulw(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // Q16 product rounding, half up
  function automatic logic signed [31:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return t[31:0];
  endfunction

  function automatic lg_t lg_norm(input logic [23:0] x);
    lg_t o;
    logic [4:0] msb;
    msb = '0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) msb = 5'(i);
    end
    o.m = 31'(x) << (5'd30 - msb);
    o.r = {msb, 16'd0};
    return o;
  endfunction

  function automatic lg_t lg_step(input lg_t a, input int bitpos);
    lg_t o;
    logic [61:0] sq;
    logic [31:0] m2;
    sq = 62'(a.m) * 62'(a.m);
    m2 = sq[61:30];
    o.r = a.r;
    if (m2[31]) begin
      o.m = m2[31:1];
      o.r = a.r | (21'd1 << bitpos);
    end else begin
      o.m = m2[30:0];
    end
    return o;
  endfunction

  function automatic int lg_q16_const(input longint unsigned x);
    int e;
    longint unsigned m;
    int r;
    e = 0;
    while ((x >> e) > 1) e++;
    m = x << (30 - e);
    r = e * 65536;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (1 << i);
      end
    end
    return r;
  endfunction

  localparam logic signed [31:0] LOG2_16000 = 32'(lg_q16_const(64'd16000));

endpackage
`default_nettype wire

### sv/hata_path_loss_cell.sv
// Top level of the Hata path loss cell: config registers and the full
// datapath pipeline. Depends on hpl_pkg.
// Throughput: one item per cycle while m_tready is high; a full pipeline stage holds
// when the one after it is full and stalled, so bubbles collapse.
// Reset: synchronous rst clears all valid bits and loads the register defaults.
`default_nettype none
module hata_path_loss_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [hpl_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [71:0]               s_tdata,  // ground_height, offset_east, offset_north
  input  wire logic                      s_tuser,  // ground_valid
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [23:0]                    m_tdata,  // path_loss
  output logic                           m_tuser   // loss_valid
);
  import hpl_pkg::*;

  logic [15:0]        frequency_mhz;
  logic [15:0]        antenna_height;
  logic signed [18:0] tx_ground_height;
  logic [22:0]        radius_limit;
  logic [1:0]         area_sel;
  logic signed [18:0] default_ground_height;
  logic [45:0]        rsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency_mhz         <= 16'd14400;
      antenna_height        <= 16'd160;
      tx_ground_height      <= '0;
      radius_limit          <= 23'd160000;
      area_sel              <= AREA_URBAN;
      default_ground_height <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FREQ:   frequency_mhz         <= cfg_data[15:0];
        REG_ANT:    antenna_height        <= cfg_data[15:0];
        REG_TXG:    tx_ground_height      <= cfg_data[18:0];
        REG_RADIUS: radius_limit          <= cfg_data[22:0];
        REG_AREA:   area_sel              <= cfg_data[1:0];
        REG_DEFG:   default_ground_height <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rsq <= 46'(radius_limit) * 46'(radius_limit);
  end

  hpl_pl_t pl  [0:NST];
  hpl_pl_t nx  [1:NST];
  logic    vld [0:NST];
  logic    rdy [1:NST];

  always_comb begin
    pl[0]   = '0;
    pl[0].h = s_tuser ? signed'(s_tdata[18:0]) : default_ground_height;
    pl[0].e = signed'(s_tdata[42:19]);
    pl[0].n = signed'(s_tdata[66:43]);
    vld[0]  = s_tvalid;
  end

  always_comb begin
    rdy[NST] = !vld[NST] || m_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[1];

  for (genvar k = 1; k <= NST; k++) begin : g_st
    always_comb begin
      logic signed [21:0] d;
      logic signed [21:0] hs;
      logic [47:0]        bitv;
      logic [47:0]        t;
      logic signed [31:0] af;
      logic signed [31:0] ah;
      logic signed [31:0] ad;
      logic signed [31:0] t1;
      logic signed [31:0] t5;
      logic signed [31:0] t6;
      logic signed [31:0] lu;
      logic signed [31:0] q;
      d    = '0;
      hs   = '0;
      bitv = '0;
      t    = '0;
      af   = '0;
      ah   = '0;
      ad   = '0;
      t1   = '0;
      t5   = '0;
      t6   = '0;
      lu   = '0;
      q    = '0;
      nx[k] = pl[k-1];
      if (k == ST_SQ) begin
        nx[k].esq = 48'(pl[k-1].e) * 48'(pl[k-1].e);
        nx[k].nsq = 48'(pl[k-1].n) * 48'(pl[k-1].n);
        d = 22'(tx_ground_height) + signed'(22'(antenna_height))
            - 22'(pl[k-1].h) - 22'sd24;
        hs = (tx_ground_height > pl[k-1].h) ? d : signed'(22'(antenna_height));
        if (hs < 0) hs = -hs;
        nx[k].heff = (hs == 0) ? 24'd1 : 24'(hs);
      end else if (k == ST_DSQ) begin
        t = pl[k-1].esq + pl[k-1].nsq;
        nx[k].inval = (t < MIN_DSQ) || (t > 48'(rsq));
        nx[k].v = t;
        nx[k].r = '0;
      end else if (k >= ST_SQRT0 && k < ST_NORM) begin
        bitv = 48'd1 << (46 - 2 * (k - ST_SQRT0));
        t = pl[k-1].r + bitv;
        if (pl[k-1].v >= t) begin
          nx[k].v = pl[k-1].v - t;
          nx[k].r = (pl[k-1].r >> 1) + bitv;
        end else begin
          nx[k].r = pl[k-1].r >> 1;
        end
      end else if (k == ST_NORM) begin
        nx[k].gf = lg_norm((frequency_mhz == '0) ? 24'd1 : 24'(frequency_mhz));
        nx[k].gh = lg_norm(pl[k-1].heff);
        nx[k].gd = lg_norm(pl[k-1].r[23:0]);
      end else if (k >= ST_LOG0 && k < ST_P0) begin
        nx[k].gf = lg_step(pl[k-1].gf, 15 - (k - ST_LOG0));
        nx[k].gh = lg_step(pl[k-1].gh, 15 - (k - ST_LOG0));
        nx[k].gd = lg_step(pl[k-1].gd, 15 - (k - ST_LOG0));
      end else if (k == ST_P0) begin
        af = signed'(32'(pl[k-1].gf.r)) - LOG2_16;
        ah = signed'(32'(pl[k-1].gh.r)) - LOG2_16;
        ad = signed'(32'(pl[k-1].gd.r)) - LOG2_16000;
        nx[k].pf = mulw(af, C_LOG10_2);
        nx[k].ph = mulw(ah, C_LOG10_2);
        nx[k].pd = mulw(ad, C_LOG10_2);
      end else if (k == ST_L) begin
        nx[k].lf = rnd16(pl[k-1].pf);
        nx[k].lh = rnd16(pl[k-1].ph);
        nx[k].ld = rnd16(pl[k-1].pd);
      end else if (k == ST_M1) begin
        nx[k].p1 = mulw(C_1_1, pl[k-1].lf);
        nx[k].p2 = mulw(C_1_56, pl[k-1].lf);
        nx[k].p3 = mulw(C_26_16, pl[k-1].lf);
        nx[k].p4 = mulw(C_13_82, pl[k-1].lh);
        nx[k].p5 = mulw(C_6_55, pl[k-1].lh);
        nx[k].p6 = mulw(pl[k-1].lf, pl[k-1].lf);
        nx[k].p7 = mulw(pl[k-1].lf - C_LOG10_28, pl[k-1].lf - C_LOG10_28);
        nx[k].p8 = mulw(C_18_33, pl[k-1].lf);
      end else if (k == ST_M2) begin
        t1 = rnd16(pl[k-1].p1);
        t5 = rnd16(pl[k-1].p5);
        t6 = rnd16(pl[k-1].p6);
        nx[k].q1 = mulw(t1 - C_0_7, C_RX_H);
        nx[k].q2 = mulw(C_44_9 - t5, pl[k-1].ld);
        nx[k].q3 = mulw(C_4_78, t6);
        nx[k].t2 = rnd16(pl[k-1].p2);
        nx[k].t3 = rnd16(pl[k-1].p3);
        nx[k].t4 = rnd16(pl[k-1].p4);
        nx[k].t7 = rnd16(pl[k-1].p7);
        nx[k].t8 = rnd16(pl[k-1].p8);
      end else if (k == ST_M3) begin
        nx[k].ahr  = rnd16(pl[k-1].q1) - (pl[k-1].t2 - C_0_8);
        nx[k].base = C_69_55 + pl[k-1].t3 - pl[k-1].t4;
        nx[k].u2   = rnd16(pl[k-1].q2);
        nx[k].u3   = rnd16(pl[k-1].q3);
      end else if (k == ST_M4) begin
        lu = pl[k-1].base - pl[k-1].ahr + pl[k-1].u2;
        case (area_sel)
          AREA_SUB:  nx[k].loss = lu - (pl[k-1].t7 <<< 1) - C_5_4;
          AREA_OPEN: nx[k].loss = lu - pl[k-1].u3 + pl[k-1].t8 - C_40_94;
          default:   nx[k].loss = lu;
        endcase
      end else if (k == NST) begin
        q = (pl[k-1].loss + 32'sd128) >>> 8;
        if (q > 32'sd8388607) q = 32'sd8388607;
        if (q < -32'sd8388608) q = -32'sd8388608;
        nx[k].po = pl[k-1].inval ? 24'd0 : q[23:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        pl[k] <= nx[k];
      end
    end
  end

  assign m_tvalid = vld[NST];
  assign m_tdata  = pl[NST].po;
  assign m_tuser  = !pl[NST].inval;

endmodule
`default_nettype wire

### sv/hpl_checker.sv
// Port-level checker for hata_path_loss_cell, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module hpl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result item changed");

  a_inval_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'd0)
    else $error("invalid item carries nonzero loss");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input blocked while output drains");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result item right after reset");

endmodule

bind hata_path_loss_cell hpl_checker u_hpl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
